FILE: design/wlsc_pkg.sv
// Shared constants, codes and token type for the weighted LRU stack cost block.
`default_nettype none
package wlsc_pkg;

    localparam int ITEMS       = 512;
    localparam int ID_W        = 9;
    localparam int WEIGHT_BITS = 16;
    localparam int IN_W_W      = 16;
    localparam int COST_W      = 25;
    localparam int TOTAL_W     = 32;

    // mode field codes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ACCESS = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        K_NOP,
        K_LOAD,
        K_ACC,
        K_CLR
    } t_kind;

    // Word travelling down the cell row.
    typedef struct packed {
        t_kind                  kind;
        logic [ID_W-1:0]        key;    // id being loaded or accessed
        logic [ID_W-1:0]        cid;    // carried entry id (access)
        logic [WEIGHT_BITS-1:0] cw;     // carried weight, or new weight on load
        logic [COST_W-1:0]      cost;
        logic                   done;
        logic                   found;
    } t_tok;

endpackage
`default_nettype wire

FILE: design/wlsc_if.sv
// Valid/ready channel interfaces for input items and result words.
`default_nettype none
interface wlsc_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   mode;
    logic [wlsc_pkg::ID_W-1:0]    item_id;
    logic [wlsc_pkg::IN_W_W-1:0]  item_weight;

    modport source (output valid, mode, item_id, item_weight, input ready);
    modport sink   (input valid, mode, item_id, item_weight, output ready);
endinterface

interface wlsc_out_if;
    logic                          valid;
    logic                          ready;
    logic [wlsc_pkg::COST_W-1:0]   access_cost;
    logic [wlsc_pkg::TOTAL_W-1:0]  running_total;
    logic                          first_access;

    modport source (output valid, access_cost, running_total, first_access, input ready);
    modport sink   (input valid, access_cost, running_total, first_access, output ready);
endinterface
`default_nettype wire

FILE: design/wlsc_entry.sv
// Entry stage: decodes the input word, holds the weight table, launches tokens.
`default_nettype none
module wlsc_entry (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,
    input  wire logic                             i_acc,
    input  wire logic [1:0]                       i_mode,
    input  wire logic [wlsc_pkg::ID_W-1:0]        i_id,
    input  wire logic [wlsc_pkg::WEIGHT_BITS-1:0] i_weight,
    output wlsc_pkg::t_tok                        o_tok
);

    logic [wlsc_pkg::WEIGHT_BITS-1:0] r_mem [wlsc_pkg::ITEMS];
    logic [wlsc_pkg::WEIGHT_BITS-1:0] r_rd;
    logic [wlsc_pkg::WEIGHT_BITS-1:0] r_ldw;
    logic [wlsc_pkg::ID_W-1:0]        r_key;
    wlsc_pkg::t_kind                  r_kind;
    wlsc_pkg::t_kind                  n_kind;
    logic                             w_in_range;

    assign w_in_range = (32'(i_id) < wlsc_pkg::ITEMS);

    always_comb begin
        n_kind = wlsc_pkg::K_NOP;
        if (i_acc) begin
            case (i_mode)
                wlsc_pkg::MODE_LOAD:   n_kind = w_in_range ? wlsc_pkg::K_LOAD : wlsc_pkg::K_NOP;
                wlsc_pkg::MODE_ACCESS: n_kind = w_in_range ? wlsc_pkg::K_ACC : wlsc_pkg::K_NOP;
                wlsc_pkg::MODE_CLEAR:  n_kind = wlsc_pkg::K_CLR;
                default:               n_kind = wlsc_pkg::K_NOP;
            endcase
        end
    end

    // weight table: written on an accepted load, read for every entering word
    always_ff @(posedge i_clk) begin
        if (n_kind == wlsc_pkg::K_LOAD) begin
            r_mem[i_id] <= i_weight;
        end
        if (i_en) begin
            r_rd <= r_mem[i_id];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= wlsc_pkg::K_NOP;
        end else if (i_en) begin
            r_kind <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_key <= i_id;
            r_ldw <= i_weight;
        end
    end

    always_comb begin
        o_tok       = '0;
        o_tok.kind  = r_kind;
        o_tok.key   = r_key;
        o_tok.cid   = r_key;
        o_tok.cw    = (r_kind == wlsc_pkg::K_LOAD) ? r_ldw : r_rd;
        o_tok.cost  = '0;
        o_tok.done  = 1'b0;
        o_tok.found = 1'b0;
    end

endmodule
`default_nettype wire

FILE: design/wlsc_cell.sv
// One stack slot: matches, swaps and accumulates as a token passes through.
`default_nettype none
module wlsc_cell (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire wlsc_pkg::t_tok i_tok,
    output wlsc_pkg::t_tok o_tok
);

    logic [wlsc_pkg::ID_W-1:0]        r_id;
    logic [wlsc_pkg::WEIGHT_BITS-1:0] r_w;
    logic                             r_valid;
    wlsc_pkg::t_tok                   r_tok;

    logic [wlsc_pkg::ID_W-1:0]        n_id;
    logic [wlsc_pkg::WEIGHT_BITS-1:0] n_w;
    logic                             n_valid;
    wlsc_pkg::t_tok                   n_tok;
    logic                             w_hit;
    logic [wlsc_pkg::COST_W:0]        w_sum;

    assign w_hit = r_valid && (r_id == i_tok.key);
    assign w_sum = {1'b0, i_tok.cost} + (wlsc_pkg::COST_W + 1)'(r_w);

    always_comb begin
        n_tok   = i_tok;
        n_id    = r_id;
        n_w     = r_w;
        n_valid = r_valid;
        case (i_tok.kind)
            wlsc_pkg::K_CLR: begin
                n_valid = 1'b0;
            end
            wlsc_pkg::K_LOAD: begin
                if (w_hit) begin
                    n_w = i_tok.cw;
                end
            end
            wlsc_pkg::K_ACC: begin
                if (!i_tok.done) begin
                    // slot always takes the carried entry; old one moves down
                    n_id    = i_tok.cid;
                    n_w     = i_tok.cw;
                    n_valid = 1'b1;
                    if (w_hit) begin
                        n_tok.done  = 1'b1;
                        n_tok.found = 1'b1;
                    end else if (r_valid) begin
                        n_tok.cid  = r_id;
                        n_tok.cw   = r_w;
                        n_tok.cost = w_sum[wlsc_pkg::COST_W] ? '1
                                                             : w_sum[wlsc_pkg::COST_W-1:0];
                    end else begin
                        n_tok.done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_tok.kind <= wlsc_pkg::K_NOP;
        end else if (i_en) begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
            r_id    <= n_id;
            r_w     <= n_w;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

FILE: design/weighted_lru_stack_cost.sv
// Top level: entry stage, row of stack cells and result/total output stage.
//
// Every input word (load, access or clear) becomes a token that walks the row of
// ITEMS stack cells, one cell per cycle unless stalled, top of stack first. In each
// cell an access token adds the slot's weight and swaps the carried entry into the
// slot until it finds its id or an empty slot, which realizes move-to-front in
// passing; a load token updates the weight of a matching slot, a clear token empties
// every slot. Tokens follow each other cycle by cycle, so the block accepts one word
// per cycle while not stalled and returns access results in order, through the entry
// register, the cell registers and the result register. When the result register is
// held by the sink the whole row stalls, and input ready drops with it.
`default_nettype none
module weighted_lru_stack_cost (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wlsc_in_if.sink    i_in,
    wlsc_out_if.source o_out
);

    wlsc_pkg::t_tok w_tok [wlsc_pkg::ITEMS + 1];

    logic                             w_en;
    logic                             w_acc;
    logic [wlsc_pkg::TOTAL_W:0]       w_tot_sum;
    logic [wlsc_pkg::TOTAL_W-1:0]     w_tot_sat;

    logic                             r_out_valid;
    logic [wlsc_pkg::COST_W-1:0]      r_cost;
    logic [wlsc_pkg::TOTAL_W-1:0]     r_tot_o;
    logic                             r_first;
    logic [wlsc_pkg::TOTAL_W-1:0]     r_total;

    assign w_en  = !r_out_valid || o_out.ready;
    assign w_acc = i_in.valid && w_en;
    assign i_in.ready = w_en;

    wlsc_entry u_entry (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_acc    (w_acc),
        .i_mode   (i_in.mode),
        .i_id     (i_in.item_id),
        .i_weight (i_in.item_weight[wlsc_pkg::WEIGHT_BITS-1:0]),
        .o_tok    (w_tok[0])
    );

    for (genvar g = 0; g < wlsc_pkg::ITEMS; g++) begin : g_cell
        wlsc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_tot_sum = {1'b0, r_total}
                     + (wlsc_pkg::TOTAL_W + 1)'(w_tok[wlsc_pkg::ITEMS].cost);
    assign w_tot_sat = w_tot_sum[wlsc_pkg::TOTAL_W] ? '1
                                                    : w_tot_sum[wlsc_pkg::TOTAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else if (w_en) begin
            r_out_valid <= (w_tok[wlsc_pkg::ITEMS].kind == wlsc_pkg::K_ACC);
            case (w_tok[wlsc_pkg::ITEMS].kind)
                wlsc_pkg::K_ACC: r_total <= w_tot_sat;
                wlsc_pkg::K_CLR: r_total <= '0;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cost  <= w_tok[wlsc_pkg::ITEMS].cost;
            r_tot_o <= w_tot_sat;
            r_first <= !w_tok[wlsc_pkg::ITEMS].found;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.access_cost   = r_cost;
    assign o_out.running_total = r_tot_o;
    assign o_out.first_access  = r_first;

    // a stalled row must not move
    a_row_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_tok[wlsc_pkg::ITEMS].kind))
        else $error("cell row advanced while stalled");

    // total only falls on a clear
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tok[wlsc_pkg::ITEMS].kind != wlsc_pkg::K_CLR) |=> (r_total >= $past(r_total)))
        else $error("running total decreased without clear");

    // reported total always includes the reported cost
    a_out_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.running_total >= wlsc_pkg::TOTAL_W'(o_out.access_cost)))
        else $error("running total below access cost");

endmodule
`default_nettype wire

FILE: tb/wlsc_checker.sv
// Checker: tracks the weight table and MRU stack, predicts access costs and compares results.
`timescale 1ns / 100ps
module wlsc_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wlsc_in_if        i_in_ch,
    wlsc_out_if       i_out_ch,
    output int        o_fail_count,
    output int        o_pending
);
    import wlsc_pkg::*;

    localparam longint unsigned COST_SAT  = (64'd1 << COST_W) - 64'd1;
    localparam longint unsigned TOTAL_SAT = (64'd1 << TOTAL_W) - 64'd1;
    localparam int              REPORT_LIMIT = 10;

    typedef struct {
        logic [COST_W-1:0]  cost;
        logic [TOTAL_W-1:0] total;
        logic               first;
    } t_access_result;

    logic [WEIGHT_BITS-1:0] weight_mem [ITEMS];
    logic [ID_W-1:0]        mru_ids [$];      // index 0 is the top of the stack
    logic [TOTAL_W-1:0]     cost_total;
    t_access_result         expected_costs [$];
    t_access_result         want;
    t_access_result         seen;
    int                     fail_count = 0;

    // Walks the stack from the top, summing weights until the id turns up,
    // then moves (or pushes) the id to the top.
    function automatic t_access_result access_cost_of(input logic [ID_W-1:0] id);
        t_access_result   res;
        longint unsigned  sum;
        longint unsigned  acc;
        int               pos;
        sum = 0;
        pos = -1;
        for (int k = 0; k < mru_ids.size(); k++) begin
            if (mru_ids[k] == id) begin
                pos = k;
                break;
            end
            sum += weight_mem[mru_ids[k]];
        end
        if (pos >= 0)
            mru_ids.delete(pos);
        mru_ids.insert(0, id);
        if (sum > COST_SAT)
            sum = COST_SAT;
        acc = longint'(cost_total) + sum;
        if (acc > TOTAL_SAT)
            acc = TOTAL_SAT;
        cost_total = acc[TOTAL_W-1:0];
        res.cost  = sum[COST_W-1:0];
        res.total = cost_total;
        res.first = (pos < 0);
        return res;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < REPORT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mru_ids.delete();
            expected_costs.delete();
            cost_total = '0;
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                case (i_in_ch.mode)
                    MODE_LOAD:   weight_mem[i_in_ch.item_id] = i_in_ch.item_weight[WEIGHT_BITS-1:0];
                    MODE_ACCESS: begin
                        want = access_cost_of(i_in_ch.item_id);
                        expected_costs.insert(expected_costs.size(), want);
                    end
                    MODE_CLEAR: begin
                        mru_ids.delete();
                        cost_total = '0;
                    end
                    default: ;  // unused mode, ignored
                endcase
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                seen.cost  = i_out_ch.access_cost;
                seen.total = i_out_ch.running_total;
                seen.first = i_out_ch.first_access;
                if (expected_costs.size() == 0) begin
                    note_failure($sformatf("unexpected result word: cost %0d total %0d first %0b",
                                           seen.cost, seen.total, seen.first));
                end else begin
                    want = expected_costs.pop_front();
                    if (seen.cost !== want.cost || seen.total !== want.total ||
                        seen.first !== want.first)
                        note_failure($sformatf({"result mismatch: cost %0d/%0d ",
                                                "total %0d/%0d first %0b/%0b (exp/got)"},
                                               want.cost, seen.cost, want.total, seen.total,
                                               want.first, seen.first));
                end
            end
        end
        o_pending    <= expected_costs.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: tb/tb_weighted_lru_stack_cost.sv
// Testbench top: clock, reset, stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 100ps
module tb_weighted_lru_stack_cost;
    import wlsc_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         RANDOM_WORDS = 510;
    localparam int         IDLE_LIMIT   = 4000;
    localparam int         DRAIN_CYCLES = ITEMS + 20;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_pattern;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_ready = 1'b1;
    logic [3:0]  rx_phase = '0;
    t_rx_pattern rx_pattern = RX_OPEN;
    int          idle_cycles = 0;
    int          fail_count;
    int          pending;
    int          words_sent = 0;
    int          burst_left = 0;
    bit          no_gaps = 1'b0;
    bit          loaded [ITEMS];

    wlsc_in_if  in_ch ();
    wlsc_out_if out_ch ();

    assign out_ch.ready = rx_ready;

    weighted_lru_stack_cost u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    wlsc_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        rx_phase <= rx_phase + 4'd1;
        case (rx_pattern)
            RX_OPEN:   rx_ready <= 1'b1;
            RX_COIN:   rx_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rx_ready <= ($urandom_range(0, 7) == 0);
            default:   rx_ready <= (rx_phase < 4'd5);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic logic [IN_W_W-1:0] pick_weight();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return IN_W_W'($urandom_range(0, 15));
            default: return IN_W_W'($urandom);
        endcase
    endfunction

    // Drives one word and holds it until accepted; bursts are broken by random gaps unless no_gaps is set.
    task automatic send_word(input logic [1:0] mode, input logic [ID_W-1:0] id,
                             input logic [IN_W_W-1:0] weight);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!no_gaps) begin
                gap = $urandom_range(1, 8);
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= mode;
        in_ch.item_id     <= id;
        in_ch.item_weight <= weight;
        do @(posedge clk); while (!in_ch.ready);
        if (mode == MODE_LOAD)
            loaded[id] = 1'b1;
        if (mode != MODE_UNUSED)
            words_sent++;
    endtask

    task automatic access_id(input logic [ID_W-1:0] id);
        send_word(MODE_ACCESS, id, IN_W_W'($urandom));
    endtask

    // Stops sending until every outstanding access result has come back.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        logic [ID_W-1:0] pool [$];
        logic [ID_W-1:0] id;
        int              pool_size;
        int              steps;
        int              pick;
        int              base;

        in_ch.valid       <= 1'b0;
        in_ch.mode        <= MODE_LOAD;
        in_ch.item_id     <= '0;
        in_ch.item_weight <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every mode, hits at top and bottom, empty stack
        send_word(MODE_LOAD, 9'd0, 16'h0000);
        send_word(MODE_LOAD, 9'd511, 16'hFFFF);
        send_word(MODE_LOAD, 9'd256, 16'h0001);
        send_word(MODE_LOAD, 9'd170, 16'hAAAA);
        send_word(MODE_LOAD, 9'd341, 16'h5555);
        send_word(MODE_UNUSED, 9'd511, 16'hFFFF);
        access_id(9'd0);
        access_id(9'd511);
        access_id(9'd256);
        access_id(9'd0);                        // found at the bottom
        access_id(9'd0);                        // already on top
        send_word(MODE_LOAD, 9'd511, 16'h1234); // weight change while stacked
        access_id(9'd170);
        access_id(9'd511);
        send_word(MODE_CLEAR, 9'd0, 16'h0000);
        access_id(9'd341);                      // first access into an empty stack
        access_id(9'd341);
        send_word(MODE_LOAD, 9'd341, 16'h0000);
        access_id(9'd511);
        send_word(MODE_UNUSED, 9'd0, 16'h0000);
        send_word(MODE_CLEAR, 9'd511, 16'hFFFF);
        wait_for_results();

        base = words_sent;
        while (words_sent - base < RANDOM_WORDS) begin
            rx_pattern = t_rx_pattern'($urandom_range(0, 3));
            no_gaps    = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            pool.delete();
            pool_size = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160)
                                                    : $urandom_range(1, 16);
            repeat (pool_size) begin
                id = ID_W'($urandom_range(0, ITEMS - 1));
                pool.insert(pool.size(), id);
                if (!loaded[id] || $urandom_range(0, 3) == 0)
                    send_word(MODE_LOAD, id, pick_weight());
            end
            if ($urandom_range(0, 1))
                send_word(MODE_CLEAR, ID_W'($urandom), IN_W_W'($urandom));
            steps = $urandom_range(10, 60);
            repeat (steps) begin
                pick = $urandom_range(0, 99);
                if (pick < 78) begin
                    access_id(pool[$urandom_range(0, pool.size() - 1)]);
                end else if (pick < 86) begin
                    send_word(MODE_LOAD, pool[$urandom_range(0, pool.size() - 1)],
                              pick_weight());
                end else if (pick < 91) begin
                    send_word(MODE_UNUSED, ID_W'($urandom), IN_W_W'($urandom));
                end else if (pick < 94) begin
                    send_word(MODE_CLEAR, ID_W'($urandom), IN_W_W'($urandom));
                end else begin
                    id = ID_W'($urandom_range(0, ITEMS - 1));
                    if (loaded[id])
                        access_id(id);
                    else
                        send_word(MODE_LOAD, id, pick_weight());
                end
            end
            if ($urandom_range(0, 2) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/wlsc_pkg.sv
design/wlsc_if.sv
design/wlsc_entry.sv
design/wlsc_cell.sv
design/weighted_lru_stack_cost.sv
tb/wlsc_checker.sv
tb/tb_weighted_lru_stack_cost.sv
